/* rtl/mfrh_pkg.sv */
`default_nettype none

package mfrh_pkg;

    localparam logic [63:0] SEED_RESET = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] P1         = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2         = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3         = 64'h165667B19E3779F9;
    localparam logic [63:0] P4         = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5         = 64'h027D4EB2F165B7D1;

    localparam int ROT         = 11;
    localparam int FIN_SHIFT_A = 37;
    localparam int FIN_SHIFT_B = 32;

    localparam logic [4:0] FULL_COUNT = 5'd16;
    localparam logic [4:0] FOLD_COUNT = 5'd8;
    localparam logic [2:0] STEPS_FOLD = 3'd4;
    localparam logic [2:0] STEPS_LOW  = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FULL,
        ST_FOLD8,
        ST_BYTE_P5,
        ST_BYTE_P1,
        ST_DONE,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

/* rtl/mfrh_if.sv */
`default_nettype none

interface mfrh_req_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic [4:0]  byte_count;
    logic        end_of_call;
    logic        finalize;

    modport source (
        output valid, start_req, chunk_low, chunk_high, byte_count, end_of_call, finalize,
        input  ready
    );
    modport sink (
        input  valid, start_req, chunk_low, chunk_high, byte_count, end_of_call, finalize,
        output ready
    );
endinterface

interface mfrh_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        is_finalized;

    modport source (
        output valid, hash_value, is_finalized,
        input  ready
    );
    modport sink (
        input  valid, hash_value, is_finalized,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/mul_fold_rolling_hash64_core.sv */
`default_nettype none

// Keyed 64-bit rolling hash. One request carries up to 16 message bytes; a
// result is returned only for requests that end a call. All products run
// through a single 32x32 multiplier, one partial product per cycle, so the
// request port is busy while a request is worked on. A full 16-byte request
// is one folded multiply; a tail folds its first eight bytes if it has them
// and takes one multiply by P5 and one by P1 per further byte; a request
// with no bytes needs no multiply. Finalizing adds one multiply. The result
// sits in an output register, so the next request is taken while a result
// still waits; one that ends a call too then waits until the result is taken.
module mul_fold_rolling_hash64_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    mfrh_req_if.sink         req,
    mfrh_rsp_if.source       rsp
);

    mfrh_pkg::state_t state_reg, state_next;

    logic [2:0]   mstep_reg, mstep_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg, pp_next;
    logic [63:0]  op_a_reg, op_a_next;
    logic [63:0]  op_b_reg, op_b_next;
    logic [63:0]  hash_reg, hash_next;
    logic [63:0]  seed_reg, seed_next;
    logic [63:0]  low_reg, low_next;
    logic [63:0]  high_reg, high_next;
    logic [4:0]   count_reg, count_next;
    logic [3:0]   pos_reg, pos_next;
    logic         eoc_reg, eoc_next;
    logic         fin_reg, fin_next;
    logic [63:0]  res_reg, res_next;
    logic         res_fin_reg, res_fin_next;
    logic         out_valid_reg, out_valid_next;

    logic         accept;
    logic         out_free;
    logic         in_mul;
    logic [2:0]   nsteps;
    logic         last_step;
    logic [31:0]  mul_a, mul_b;
    logic [1:0]   pj;
    logic [6:0]   shamt;
    logic [127:0] acc_sum;
    logic [63:0]  fold_r, low_r;
    logic [4:0]   in_count;
    logic [63:0]  s0;
    logic [3:0]   pos_inc;
    logic [63:0]  mix_t, rot_t, fin_h;
    logic [63:0]  pre_fin;

    function automatic logic [63:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] idx);
        logic [63:0] w;
        w = idx[3] ? hi : lo;
        return {56'd0, w[{idx[2:0], 3'b000} +: 8]};
    endfunction

    // outputs and shared multiplier
    always_comb
    begin
        req.ready      = (state_reg == mfrh_pkg::ST_IDLE);
        rsp.valid      = out_valid_reg;
        rsp.hash_value = res_reg;
        rsp.is_finalized = res_fin_reg;
        mul_a = mstep_reg[1] ? op_a_reg[63:32] : op_a_reg[31:0];
        mul_b = mstep_reg[0] ? op_b_reg[63:32] : op_b_reg[31:0];
        pp_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_mul   = (state_reg == mfrh_pkg::ST_FULL) || (state_reg == mfrh_pkg::ST_FOLD8)
                   || (state_reg == mfrh_pkg::ST_BYTE_P5) || (state_reg == mfrh_pkg::ST_BYTE_P1)
                   || (state_reg == mfrh_pkg::ST_FIN);
    assign nsteps   = ((state_reg == mfrh_pkg::ST_FULL) || (state_reg == mfrh_pkg::ST_FOLD8))
                      ? mfrh_pkg::STEPS_FOLD : mfrh_pkg::STEPS_LOW;
    assign last_step = (mstep_reg == nsteps);
    assign pj       = 2'(mstep_reg - 3'd1);
    assign shamt    = (pj == 2'd3) ? 7'd64 : ((pj[1] ^ pj[0]) ? 7'd32 : 7'd0);
    assign acc_sum  = acc_reg + ({64'd0, pp_reg} << shamt);
    assign fold_r   = acc_sum[63:0] ^ acc_sum[127:64];
    assign low_r    = acc_sum[63:0];
    assign in_count = req.byte_count[4] ? mfrh_pkg::FULL_COUNT : req.byte_count;
    assign s0       = req.start_req ? seed_reg : hash_reg;
    assign pos_inc  = pos_reg + 4'd1;
    assign mix_t    = hash_reg ^ low_r;
    assign rot_t    = {mix_t[63-mfrh_pkg::ROT:0], mix_t[63:64-mfrh_pkg::ROT]};
    assign fin_h    = low_r ^ (low_r >> mfrh_pkg::FIN_SHIFT_B);
    assign pre_fin  = hash_reg ^ (hash_reg >> mfrh_pkg::FIN_SHIFT_A);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mfrh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_count == mfrh_pkg::FULL_COUNT)
                        state_next = mfrh_pkg::ST_FULL;
                    else if (in_count >= mfrh_pkg::FOLD_COUNT)
                        state_next = mfrh_pkg::ST_FOLD8;
                    else if (in_count != 5'd0)
                        state_next = mfrh_pkg::ST_BYTE_P5;
                    else
                        state_next = mfrh_pkg::ST_DONE;
                end
            end
            mfrh_pkg::ST_FULL:
            begin
                if (last_step)
                    state_next = mfrh_pkg::ST_DONE;
            end
            mfrh_pkg::ST_FOLD8:
            begin
                if (last_step)
                    state_next = (count_reg > mfrh_pkg::FOLD_COUNT) ? mfrh_pkg::ST_BYTE_P5
                                                                     : mfrh_pkg::ST_DONE;
            end
            mfrh_pkg::ST_BYTE_P5:
            begin
                if (last_step)
                    state_next = mfrh_pkg::ST_BYTE_P1;
            end
            mfrh_pkg::ST_BYTE_P1:
            begin
                if (last_step)
                    state_next = ({1'b0, pos_inc} < count_reg) ? mfrh_pkg::ST_BYTE_P5
                                                               : mfrh_pkg::ST_DONE;
            end
            mfrh_pkg::ST_DONE:
            begin
                if (!eoc_reg)
                    state_next = mfrh_pkg::ST_IDLE;
                else if (out_free)
                    state_next = fin_reg ? mfrh_pkg::ST_FIN : mfrh_pkg::ST_IDLE;
            end
            mfrh_pkg::ST_FIN:
            begin
                if (last_step)
                    state_next = mfrh_pkg::ST_IDLE;
            end
            default:
                state_next = mfrh_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        mstep_next     = mstep_reg;
        acc_next       = acc_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        hash_next      = hash_reg;
        seed_next      = cfg_wr_en ? cfg_wr_data : seed_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        eoc_next       = eoc_reg;
        fin_next       = fin_reg;
        res_next       = res_reg;
        res_fin_next   = res_fin_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (in_mul)
        begin
            mstep_next = last_step ? 3'd0 : mstep_reg + 3'd1;
            acc_next   = (mstep_reg == 3'd0) ? 128'd0 : acc_sum;
        end

        case (state_reg)
            mfrh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    hash_next  = s0;
                    low_next   = req.chunk_low;
                    high_next  = req.chunk_high;
                    count_next = in_count;
                    eoc_next   = req.end_of_call;
                    fin_next   = req.finalize;
                    mstep_next = 3'd0;
                    if (in_count == mfrh_pkg::FULL_COUNT)
                    begin
                        op_a_next = req.chunk_low ^ (mfrh_pkg::P2 + s0);
                        op_b_next = req.chunk_high ^ mfrh_pkg::P3;
                    end
                    else if (in_count >= mfrh_pkg::FOLD_COUNT)
                    begin
                        op_a_next = req.chunk_low ^ mfrh_pkg::P1;
                        op_b_next = s0 ^ mfrh_pkg::P4;
                        pos_next  = 4'd8;
                    end
                    else
                    begin
                        op_a_next = byte_of(req.chunk_low, req.chunk_high, 4'd0);
                        op_b_next = mfrh_pkg::P5;
                        pos_next  = 4'd0;
                    end
                end
            end
            mfrh_pkg::ST_FULL:
            begin
                if (last_step)
                    hash_next = hash_reg + fold_r;
            end
            mfrh_pkg::ST_FOLD8:
            begin
                if (last_step)
                begin
                    hash_next = hash_reg ^ fold_r;
                    op_a_next = byte_of(low_reg, high_reg, pos_reg);
                    op_b_next = mfrh_pkg::P5;
                end
            end
            mfrh_pkg::ST_BYTE_P5:
            begin
                if (last_step)
                begin
                    op_a_next = rot_t;
                    op_b_next = mfrh_pkg::P1;
                end
            end
            mfrh_pkg::ST_BYTE_P1:
            begin
                if (last_step)
                begin
                    hash_next = low_r;
                    pos_next  = pos_inc;
                    op_a_next = byte_of(low_reg, high_reg, pos_inc);
                    op_b_next = mfrh_pkg::P5;
                end
            end
            mfrh_pkg::ST_DONE:
            begin
                if (eoc_reg && out_free)
                begin
                    mstep_next = 3'd0;
                    if (fin_reg)
                    begin
                        op_a_next = pre_fin;
                        op_b_next = mfrh_pkg::P3;
                    end
                    else
                    begin
                        res_next       = hash_reg;
                        res_fin_next   = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            mfrh_pkg::ST_FIN:
            begin
                if (last_step)
                begin
                    res_next       = fin_h;
                    res_fin_next   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mstep_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfrh_pkg::ST_IDLE;
            mstep_reg     <= 3'd0;
            hash_reg      <= 64'd0;
            seed_reg      <= mfrh_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            hash_reg      <= hash_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        pp_reg      <= pp_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        count_reg   <= count_next;
        pos_reg     <= pos_next;
        eoc_reg     <= eoc_next;
        fin_reg     <= fin_next;
        res_reg     <= res_next;
        res_fin_reg <= res_fin_next;
    end

endmodule

`default_nettype wire
